// ===== design/wpic_pkg.sv =====
// Shared types and constants for the wheel and pedal input conditioner.
package wpic_pkg;

	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_STEER_STEP = 3'd0,
		CFG_PEDAL_STEP = 3'd1,
		CFG_FIX_DRIFT  = 3'd2,
		CFG_STEER_MIN  = 3'd3,
		CFG_STEER_MAX  = 3'd4,
		CFG_PEDAL_MIN  = 3'd5,
		CFG_PEDAL_MAX  = 3'd6
	} cfg_idx_t;

	localparam logic [7:0] CENTRE = 8'h80;
	localparam logic [7:0] PEDAL_ZERO = 8'h30;
	localparam logic [7:0] LEVEL_MAX = 8'hFF;
	localparam logic [6:0] STEER_OUT_LIMIT = 7'h7F;
	localparam logic signed [9:0] DRIFT_LIMIT = 10'sd2;

	// (a * 256) / 0x70 == (a * 2341) >> 10 for a in 0..128
	localparam logic [11:0] STEER_RECIP = 12'd2341;
	localparam int unsigned STEER_SHIFT = 10;
	// (m * 256) / 0x61 == (m * 43241) >> 14 for m in 0..207
	localparam logic [15:0] PEDAL_RECIP = 16'd43241;
	localparam int unsigned PEDAL_SHIFT = 14;

	typedef struct packed {
		logic       left_held;
		logic       right_held;
		logic       accel_held;
		logic       brake_held;
		logic       wheel_axis_active;
		logic       accel_axis_active;
		logic       brake_axis_active;
		logic [7:0] wheel_sample;
		logic [7:0] accel_sample;
		logic [7:0] brake_sample;
		logic       crash_active;
	} in_item_t;

endpackage

// ===== design/wheel_pedal_input_conditioner.sv =====
// Wheel and pedal input conditioner: one frame tick in, one conditioned result out.
//
// Each accepted request is one frame tick. It is captured in an input register; from there the
// steering ramp, both pedal ramps, clamps, drift test and constant-reciprocal scaling run in
// one pass into the result register while the running state (steering position, drift, held
// scaled steering, pedal levels) updates. A new request is taken every cycle as long as the
// result side keeps up, and a stalled result holds only the request behind it. Configuration
// writes are expected only while no request is in flight.
module wheel_pedal_input_conditioner
	import wpic_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,

	input  logic                         cfg_we,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data,

	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         left_held,
	input  logic                         right_held,
	input  logic                         accel_held,
	input  logic                         brake_held,
	input  logic                         wheel_axis_active,
	input  logic                         accel_axis_active,
	input  logic                         brake_axis_active,
	input  logic [7:0]                   wheel_sample,
	input  logic [7:0]                   accel_sample,
	input  logic [7:0]                   brake_sample,
	input  logic                         crash_active,

	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [7:0]                   steer_position,
	output logic signed [7:0]            steer_scaled,
	output logic [7:0]                   accel_level,
	output logic signed [10:0]           accel_scaled,
	output logic [7:0]                   brake_level,
	output logic signed [10:0]           brake_scaled
);

	// configuration
	logic [6:0] steer_step_q;
	logic [7:0] pedal_step_q;
	logic       fix_drift_q;
	logic [7:0] steer_min_q;
	logic [7:0] steer_max_q;
	logic [7:0] pedal_min_q;
	logic [7:0] pedal_max_q;

	// running state
	logic [7:0]        steer_pos_q;
	logic signed [9:0] steer_drift_q;
	logic signed [7:0] steer_out_q;
	logic [7:0]        accel_q;
	logic [7:0]        brake_q;

	// pipeline
	logic     s1_valid_q;
	in_item_t item_s1;
	logic     out_valid_q;
	logic     advance;

	logic [7:0]        steer_pos_d;
	logic signed [9:0] drift_sum;
	logic              steer_refresh;
	logic signed [7:0] steer_out_d;
	logic [7:0]        accel_d;
	logic [7:0]        brake_d;
	logic signed [10:0] accel_sc_d;
	logic signed [10:0] brake_sc_d;

	function automatic logic [7:0] pedal_ramp(input logic held, input logic axis,
		input logic [7:0] sample, input logic [7:0] level, input logic [7:0] step);
		logic [8:0] up;
		logic [8:0] down;
		up = {1'b0, level} + {1'b0, step};
		down = {1'b0, level} - {1'b0, step};
		if (held) begin
			pedal_ramp = up[8] ? LEVEL_MAX : up[7:0];
		end else if (axis) begin
			pedal_ramp = sample;
		end else begin
			pedal_ramp = down[8] ? 8'd0 : down[7:0];
		end
	endfunction

	function automatic logic signed [10:0] pedal_scale(input logic [7:0] level,
		input logic [7:0] lo, input logic [7:0] hi);
		logic [7:0]        v;
		logic signed [8:0] t;
		logic [7:0]        m;
		logic [23:0]       prod;
		logic [9:0]        q;
		if (level < lo) begin
			v = lo;
		end else if (level > hi) begin
			v = hi;
		end else begin
			v = level;
		end
		t = $signed({1'b0, v}) - $signed({1'b0, PEDAL_ZERO});
		m = t[8] ? 8'(-t) : t[7:0];
		prod = {16'd0, m} * {8'd0, PEDAL_RECIP};
		q = prod[PEDAL_SHIFT +: 10];
		pedal_scale = t[8] ? -$signed({1'b0, q}) : $signed({1'b0, q});
	endfunction

	function automatic logic signed [7:0] steer_scale(input logic [7:0] pos);
		logic signed [8:0] d;
		logic [7:0]        a;
		logic [19:0]       prod;
		logic [9:0]        q;
		logic [6:0]        lim;
		d = $signed({1'b0, pos}) - $signed({1'b0, CENTRE});
		a = d[8] ? 8'(-d) : d[7:0];
		prod = {12'd0, a} * {8'd0, STEER_RECIP};
		q = prod[STEER_SHIFT +: 10];
		lim = (q > {3'd0, STEER_OUT_LIMIT}) ? STEER_OUT_LIMIT : q[6:0];
		steer_scale = d[8] ? -$signed({1'b0, lim}) : $signed({1'b0, lim});
	endfunction

	assign advance = s1_valid_q && (!out_valid_q || !out_stall);
	assign in_stall = s1_valid_q && !advance;

	// steering ramp and clamp
	always_comb begin
		logic signed [9:0] p;
		logic signed [9:0] lo;
		logic signed [9:0] hi;
		logic signed [9:0] ctr;
		logic signed [9:0] stp;
		p = $signed({2'b00, steer_pos_q});
		lo = $signed({2'b00, steer_min_q});
		hi = $signed({2'b00, steer_max_q});
		ctr = $signed({2'b00, CENTRE});
		stp = $signed({3'b000, steer_step_q});
		if (item_s1.wheel_axis_active && !item_s1.left_held && !item_s1.right_held) begin
			p = $signed({2'b00, item_s1.wheel_sample});
		end else if (item_s1.left_held) begin
			if (p > ctr) p = ctr;
			p = p - stp;
			if (p < lo) p = lo;
		end else if (item_s1.right_held) begin
			if (p < ctr) p = ctr;
			p = p + stp;
			if (p > hi) p = hi;
		end else if (p < ctr) begin
			p = p + stp;
			if (p > ctr) p = ctr;
		end else if (p > ctr) begin
			p = p - stp;
			if (p < ctr) p = ctr;
		end
		if (p < lo) begin
			p = lo;
		end else if (p > hi) begin
			p = hi;
		end
		steer_pos_d = p[7:0];
	end

	// previous position equals the stored position, so drift adds the change in position
	assign drift_sum = steer_drift_q + ($signed({2'b00, steer_pos_d})
		- $signed({2'b00, steer_pos_q}));
	assign steer_refresh = fix_drift_q || (drift_sum > DRIFT_LIMIT)
		|| (drift_sum < -DRIFT_LIMIT);
	assign steer_out_d = !steer_refresh ? steer_out_q
		: (item_s1.crash_active ? 8'sd0 : steer_scale(steer_pos_d));

	assign accel_d = pedal_ramp(item_s1.accel_held, item_s1.accel_axis_active,
		item_s1.accel_sample, accel_q, pedal_step_q);
	assign brake_d = pedal_ramp(item_s1.brake_held, item_s1.brake_axis_active,
		item_s1.brake_sample, brake_q, pedal_step_q);
	assign accel_sc_d = pedal_scale(accel_d, pedal_min_q, pedal_max_q);
	assign brake_sc_d = pedal_scale(brake_d, pedal_min_q, pedal_max_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steer_step_q <= 7'd3;
			pedal_step_q <= 8'd16;
			fix_drift_q <= 1'b0;
			steer_min_q <= 8'd72;
			steer_max_q <= 8'd184;
			pedal_min_q <= 8'd48;
			pedal_max_q <= 8'd144;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_STEER_STEP: steer_step_q <= cfg_data[6:0];
				CFG_PEDAL_STEP: pedal_step_q <= cfg_data;
				CFG_FIX_DRIFT:  fix_drift_q <= cfg_data[0];
				CFG_STEER_MIN:  steer_min_q <= cfg_data;
				CFG_STEER_MAX:  steer_max_q <= cfg_data;
				CFG_PEDAL_MIN:  pedal_min_q <= cfg_data;
				CFG_PEDAL_MAX:  pedal_max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steer_pos_q <= CENTRE;
			steer_drift_q <= '0;
			steer_out_q <= '0;
			accel_q <= '0;
			brake_q <= '0;
		end else if (advance) begin
			steer_pos_q <= steer_pos_d;
			steer_drift_q <= steer_refresh ? 10'sd0 : drift_sum;
			steer_out_q <= steer_out_d;
			accel_q <= accel_d;
			brake_q <= brake_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				s1_valid_q <= 1'b1;
			end else if (advance) begin
				s1_valid_q <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= '{left_held: left_held, right_held: right_held,
				accel_held: accel_held, brake_held: brake_held,
				wheel_axis_active: wheel_axis_active,
				accel_axis_active: accel_axis_active,
				brake_axis_active: brake_axis_active,
				wheel_sample: wheel_sample, accel_sample: accel_sample,
				brake_sample: brake_sample, crash_active: crash_active};
		end
		if (advance) begin
			steer_position <= steer_pos_d;
			steer_scaled <= steer_out_d;
			accel_level <= accel_d;
			accel_scaled <= accel_sc_d;
			brake_level <= brake_d;
			brake_scaled <= brake_sc_d;
		end
	end

	assign out_valid = out_valid_q;

endmodule
